### src/ratc_pkg.sv
// Shared types and constants for the row argmax threshold compare block.
package ratc_pkg;

  localparam int VALUE_W    = 16;  // signed Q4.12 coefficient
  localparam int MAG_W      = 15;  // saturated magnitude
  localparam int THR_W      = 15;  // threshold register
  localparam int PRIMARY_W  = 6;   // reported column number
  localparam int MASK_OUT_W = 32;  // reported column mask
  localparam int TOTAL_W    = 16;  // reported running counts

  localparam logic [MAG_W-1:0] MAG_MAX         = '1;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 15'd1229;  // 0.3 in Q4.12

  // Per-cycle control from the row sequencer to each side's tracker.
  typedef struct packed {
    logic step;   // usable in-range cell advances this cycle
    logic first;  // no usable cell seen yet in this row
    logic clear;  // row closes this cycle
  } side_ctl_t;

endpackage

### src/ratc_if.sv
// Stream channel interfaces: cell pair input and row result output.
interface ratc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ratc_pkg::VALUE_W-1:0] x_value;
  logic signed [ratc_pkg::VALUE_W-1:0] y_value;
  logic                                x_missing;
  logic                                y_missing;
  logic                                row_end;
  logic                                matrix_end;

  modport source (
    output valid, x_value, y_value, x_missing, y_missing, row_end, matrix_end,
    input  ready
  );
  modport sink (
    input  valid, x_value, y_value, x_missing, y_missing, row_end, matrix_end,
    output ready
  );
endinterface

interface ratc_out_if;
  logic                                valid;
  logic                                ready;
  logic [ratc_pkg::PRIMARY_W-1:0]      x_lead_col;
  logic [ratc_pkg::PRIMARY_W-1:0]      y_lead_col;
  logic                                row_has_data;
  logic [ratc_pkg::MASK_OUT_W-1:0]     x_mask;
  logic [ratc_pkg::MASK_OUT_W-1:0]     y_mask;
  logic                                primary_differs;
  logic                                set_differs;
  logic [ratc_pkg::TOTAL_W-1:0]        diff_primary_total;
  logic [ratc_pkg::TOTAL_W-1:0]        diff_set_total;
  logic [ratc_pkg::TOTAL_W-1:0]        comparable_rows;
  logic                                totals_valid;
  logic                                last_row;

  modport source (
    output valid, x_lead_col, y_lead_col, row_has_data, x_mask, y_mask,
           primary_differs, set_differs, diff_primary_total, diff_set_total,
           comparable_rows, totals_valid, last_row,
    input  ready
  );
  modport sink (
    input  valid, x_lead_col, y_lead_col, row_has_data, x_mask, y_mask,
           primary_differs, set_differs, diff_primary_total, diff_set_total,
           comparable_rows, totals_valid, last_row,
    output ready
  );
endinterface

### src/ratc_side.sv
// One side's row tracker: magnitude, first-largest column and threshold mask.
module ratc_side #(
  parameter int MAX_COLS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ratc_pkg::side_ctl_t                 ctl,
  input  logic signed [ratc_pkg::VALUE_W-1:0] value,
  input  logic [$clog2(MAX_COLS+1)-1:0]       col_idx,
  input  logic [ratc_pkg::THR_W-1:0]          threshold,
  output logic [$clog2(MAX_COLS+1)-1:0]       best_col_now,
  output logic [MAX_COLS-1:0]                 mask_now
);

  localparam int COL_W = $clog2(MAX_COLS + 1);

  logic [ratc_pkg::VALUE_W-1:0] neg;
  logic [ratc_pkg::MAG_W-1:0]   mag;
  logic                         take;
  logic [ratc_pkg::MAG_W-1:0]   best_mag_r;
  logic [ratc_pkg::MAG_W-1:0]   best_mag_now;
  logic [COL_W-1:0]             best_col_r;
  logic [MAX_COLS-1:0]          mask_r;

  // -32768 negates to itself; saturate it to the largest magnitude.
  assign neg  = ~value + ratc_pkg::VALUE_W'(1);
  assign mag  = value[ratc_pkg::VALUE_W-1]
                ? (neg[ratc_pkg::VALUE_W-1] ? ratc_pkg::MAG_MAX
                                            : neg[ratc_pkg::MAG_W-1:0])
                : value[ratc_pkg::MAG_W-1:0];
  assign take = ctl.step && (ctl.first || (mag > best_mag_r));

  assign best_mag_now = take ? mag : best_mag_r;
  assign best_col_now = take ? (col_idx + COL_W'(1)) : best_col_r;
  assign mask_now     = mask_r
                        | ((ctl.step && (mag >= threshold))
                           ? (MAX_COLS'(1) << col_idx) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      best_mag_r <= '0;
      best_col_r <= '0;
      mask_r     <= '0;
    end else begin
      best_mag_r <= best_mag_now;
      best_col_r <= best_col_now;
      mask_r     <= mask_now;
    end
  end

endmodule

### src/row_argmax_threshold_compare.sv
// Top level: row argmax and threshold set compare of two coefficient streams.
//
//  channel  | dir | handshake          | moves
//  ---------+-----+--------------------+-------------------------------------
//  in_ch    | in  | valid/ready        | one cell pair (x, y, missing, ends)
//  out_ch   | out | valid/ready        | one row result with running totals
//  cfg_*    | in  | wr_en, no stall    | threshold register write
//
// One cell pair per cycle, sustained while no row-closing cell waits on a
// stalled result. A transfer lands in the input register; when that cell
// advances, the row trackers update and, on a row end, the result register
// loads. Reset (rst_n low, synchronous) clears the row state, the counts and
// both valid flags, and restores the threshold to 0.3. A stalled result holds
// only cells that close a row; other cells keep flowing past it.
module row_argmax_threshold_compare #(
  parameter int MAX_COLS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ratc_in_if.sink                     in_ch,
  ratc_out_if.source                  out_ch,
  input  logic                        cfg_wr_en,
  input  logic [ratc_pkg::THR_W-1:0]  cfg_wr_data
);

  localparam int COL_W = $clog2(MAX_COLS + 1);

  // Configuration.
  logic [ratc_pkg::THR_W-1:0] threshold_r;

  // Input register.
  logic                                s1_valid_r;
  logic                                s1_valid_nxt;
  logic signed [ratc_pkg::VALUE_W-1:0] s1_x_value_r;
  logic signed [ratc_pkg::VALUE_W-1:0] s1_y_value_r;
  logic                                s1_x_missing_r;
  logic                                s1_y_missing_r;
  logic                                s1_row_end_r;
  logic                                s1_matrix_end_r;

  // Row and running state.
  logic [COL_W-1:0]      col_idx_r;
  logic [COL_W-1:0]      col_idx_nxt;
  logic                  seen_r;
  logic                  seen_nxt;
  logic [COUNT_BITS-1:0] pd_cnt_r;
  logic [COUNT_BITS-1:0] sd_cnt_r;
  logic [COUNT_BITS-1:0] cmp_cnt_r;

  // Result register.
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic [ratc_pkg::PRIMARY_W-1:0]     out_x_lead_r;
  logic [ratc_pkg::PRIMARY_W-1:0]     out_y_lead_r;
  logic                               out_row_has_data_r;
  logic [ratc_pkg::MASK_OUT_W-1:0]    out_x_mask_r;
  logic [ratc_pkg::MASK_OUT_W-1:0]    out_y_mask_r;
  logic                               out_pd_r;
  logic                               out_sd_r;
  logic [ratc_pkg::TOTAL_W-1:0]       out_pd_total_r;
  logic [ratc_pkg::TOTAL_W-1:0]       out_sd_total_r;
  logic [ratc_pkg::TOTAL_W-1:0]       out_cmp_total_r;
  logic                               out_totals_valid_r;
  logic                               out_last_row_r;

  // Datapath.
  logic                  closes;
  logic                  advance;
  logic                  emit;
  logic                  in_xfer;
  logic                  in_range;
  logic                  usable;
  logic                  seen_now;
  ratc_pkg::side_ctl_t   side_ctl;
  logic [COL_W-1:0]      x_col_now;
  logic [COL_W-1:0]      y_col_now;
  logic [MAX_COLS-1:0]   x_mask_now;
  logic [MAX_COLS-1:0]   y_mask_now;
  logic [COL_W-1:0]      x_prim;
  logic [COL_W-1:0]      y_prim;
  logic                  pd;
  logic                  sd;
  logic [COUNT_BITS-1:0] pd_cnt_now;
  logic [COUNT_BITS-1:0] sd_cnt_now;
  logic [COUNT_BITS-1:0] cmp_cnt_now;
  logic [31:0]           pd_cnt_wide;
  logic [31:0]           sd_cnt_wide;
  logic [31:0]           cmp_cnt_wide;
  logic [63:0]           x_mask_wide;
  logic [63:0]           y_mask_wide;
  logic [7:0]            x_prim_wide;
  logic [7:0]            y_prim_wide;

  // Handshake: a cell that closes a row needs a free result slot; any other
  // cell advances whenever the input register holds it.
  assign closes   = s1_row_end_r || s1_matrix_end_r;
  assign advance  = s1_valid_r && (!closes || !out_valid_r || out_ch.ready);
  assign emit     = advance && closes;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !advance);
  assign out_valid_nxt = emit || (out_valid_r && !out_ch.ready);

  // Cells past the last tracked column are dropped but still count as ends.
  assign in_range = col_idx_r < COL_W'(MAX_COLS);
  assign usable   = in_range && !s1_x_missing_r && !s1_y_missing_r;
  assign seen_now = seen_r || usable;

  assign side_ctl.step  = advance && usable;
  assign side_ctl.first = !seen_r;
  assign side_ctl.clear = emit;

  always_comb begin
    col_idx_nxt = col_idx_r;
    seen_nxt    = seen_r;
    if (advance) begin
      if (closes) begin
        col_idx_nxt = '0;
        seen_nxt    = 1'b0;
      end else begin
        col_idx_nxt = in_range ? (col_idx_r + COL_W'(1)) : col_idx_r;
        seen_nxt    = seen_now;
      end
    end
  end

  ratc_side #(.MAX_COLS(MAX_COLS)) u_side_x (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (side_ctl),
    .value        (s1_x_value_r),
    .col_idx      (col_idx_r),
    .threshold    (threshold_r),
    .best_col_now (x_col_now),
    .mask_now     (x_mask_now)
  );

  ratc_side #(.MAX_COLS(MAX_COLS)) u_side_y (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (side_ctl),
    .value        (s1_y_value_r),
    .col_idx      (col_idx_r),
    .threshold    (threshold_r),
    .best_col_now (y_col_now),
    .mask_now     (y_mask_now)
  );

  // An empty substantial set reports primary 0.
  assign x_prim = (|x_mask_now) ? x_col_now : '0;
  assign y_prim = (|y_mask_now) ? y_col_now : '0;
  assign pd     = x_prim != y_prim;
  assign sd     = x_mask_now != y_mask_now;

  // Saturating counts, bumped only for rows with usable data.
  assign cmp_cnt_now = (seen_now && !(&cmp_cnt_r)) ? cmp_cnt_r + COUNT_BITS'(1)
                                                   : cmp_cnt_r;
  assign pd_cnt_now  = (seen_now && pd && !(&pd_cnt_r)) ? pd_cnt_r + COUNT_BITS'(1)
                                                        : pd_cnt_r;
  assign sd_cnt_now  = (seen_now && sd && !(&sd_cnt_r)) ? sd_cnt_r + COUNT_BITS'(1)
                                                        : sd_cnt_r;

  assign pd_cnt_wide  = 32'(pd_cnt_now);
  assign sd_cnt_wide  = 32'(sd_cnt_now);
  assign cmp_cnt_wide = 32'(cmp_cnt_now);
  assign x_mask_wide  = 64'(x_mask_now);
  assign y_mask_wide  = 64'(y_mask_now);
  assign x_prim_wide  = 8'(x_prim);
  assign y_prim_wide  = 8'(y_prim);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= ratc_pkg::THRESHOLD_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_idx_r   <= '0;
      seen_r      <= 1'b0;
      pd_cnt_r    <= '0;
      sd_cnt_r    <= '0;
      cmp_cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        threshold_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      col_idx_r   <= col_idx_nxt;
      seen_r      <= seen_nxt;
      // Close the row; a matrix end starts the next matrix with fresh counts.
      if (emit) begin
        if (s1_matrix_end_r) begin
          pd_cnt_r  <= '0;
          sd_cnt_r  <= '0;
          cmp_cnt_r <= '0;
        end else begin
          pd_cnt_r  <= pd_cnt_now;
          sd_cnt_r  <= sd_cnt_now;
          cmp_cnt_r <= cmp_cnt_now;
        end
      end
    end
  end

  // Input payload: load on transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_x_value_r    <= in_ch.x_value;
      s1_y_value_r    <= in_ch.y_value;
      s1_x_missing_r  <= in_ch.x_missing;
      s1_y_missing_r  <= in_ch.y_missing;
      s1_row_end_r    <= in_ch.row_end;
      s1_matrix_end_r <= in_ch.matrix_end;
    end
  end

  // Result payload: load when a row closes, hold while stalled.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_lead_r       <= seen_now ? x_prim_wide[ratc_pkg::PRIMARY_W-1:0] : '0;
      out_y_lead_r       <= seen_now ? y_prim_wide[ratc_pkg::PRIMARY_W-1:0] : '0;
      out_row_has_data_r <= seen_now;
      out_x_mask_r       <= seen_now ? x_mask_wide[ratc_pkg::MASK_OUT_W-1:0] : '0;
      out_y_mask_r       <= seen_now ? y_mask_wide[ratc_pkg::MASK_OUT_W-1:0] : '0;
      out_pd_r           <= seen_now && pd;
      out_sd_r           <= seen_now && sd;
      out_pd_total_r     <= pd_cnt_wide[ratc_pkg::TOTAL_W-1:0];
      out_sd_total_r     <= sd_cnt_wide[ratc_pkg::TOTAL_W-1:0];
      out_cmp_total_r    <= cmp_cnt_wide[ratc_pkg::TOTAL_W-1:0];
      out_totals_valid_r <= |cmp_cnt_now;
      out_last_row_r     <= s1_matrix_end_r;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.x_lead_col         = out_x_lead_r;
  assign out_ch.y_lead_col         = out_y_lead_r;
  assign out_ch.row_has_data       = out_row_has_data_r;
  assign out_ch.x_mask             = out_x_mask_r;
  assign out_ch.y_mask             = out_y_mask_r;
  assign out_ch.primary_differs    = out_pd_r;
  assign out_ch.set_differs        = out_sd_r;
  assign out_ch.diff_primary_total = out_pd_total_r;
  assign out_ch.diff_set_total     = out_sd_total_r;
  assign out_ch.comparable_rows    = out_cmp_total_r;
  assign out_ch.totals_valid       = out_totals_valid_r;
  assign out_ch.last_row           = out_last_row_r;

endmodule
